// ----- hdl/fixed_point_alu_assert.svh -----
// Assertion macros used by the checker file of the fixed-point ALU.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fpa_pkg.sv -----
`default_nettype none

package fpa_pkg;

    localparam int DATA_W         = 32;
    localparam int OP_W           = 4;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int WORD_BITS_DEF  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_INT2FIX = 4'd14,
        OP_FIX2INT = 4'd15
    } fpa_op_t;

    // Per-word control that travels beside the datapath through every stage.
    typedef struct packed {
        fpa_op_t           op;
        logic              neg;
        logic [DATA_W-1:0] value;
        logic              cmp;
        logic              ovf;
        logic              dbz;
    } fpa_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/fpa_front.sv -----
`default_nettype none

module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [fpa_pkg::OP_W-1:0]       in_op,
    input  wire logic [fpa_pkg::DATA_W-1:0]     in_a,
    input  wire logic [fpa_pkg::DATA_W-1:0]     in_b,
    output logic                                out_valid,
    output fpa_pkg::fpa_ctl_t                   out_ctl,
    output logic [2*WORD_BITS-1:0]              out_prod,
    output logic [WORD_BITS+FRAC_BITS-1:0]      out_num,
    output logic [WORD_BITS-1:0]                out_den
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int XW = W + F + 1;

    logic signed [W-1:0]  a_w;
    logic signed [W-1:0]  b_w;
    logic signed [W:0]    add_s;
    logic signed [W:0]    sub_s;
    logic signed [W:0]    inc_s;
    logic signed [W:0]    dec_s;
    logic signed [XW-1:0] wide_s;
    logic [W:0]           clamped;
    logic signed [W-1:0]  res_v;
    fpa_op_t              op_w;
    fpa_ctl_t             ctl_next;
    logic [W-1:0]         ma_next;
    logic [W-1:0]         mb_next;

    logic                 v1_reg;
    fpa_ctl_t             ctl1_reg;
    logic [W-1:0]         ma_reg;
    logic [W-1:0]         mb_reg;
    logic                 v2_reg;
    fpa_ctl_t             ctl2_reg;
    logic [2*W-1:0]       prod_reg;
    logic [W+F-1:0]       num_reg;
    logic [W-1:0]         den_reg;

    function automatic logic [W:0] clamp(input logic signed [XW-1:0] v);
        logic [XW-W:0] hi;
        hi = v[XW-1:W-1];
        if (&hi || ~|hi)
        begin
            clamp = {1'b0, v[W-1:0]};
        end
        else if (v[XW-1])
        begin
            clamp = {2'b11, {(W-1){1'b0}}};
        end
        else
        begin
            clamp = {2'b10, {(W-1){1'b1}}};
        end
    endfunction

    assign a_w   = in_a[W-1:0];
    assign b_w   = in_b[W-1:0];
    assign op_w  = fpa_op_t'(in_op);
    assign add_s = (W+1)'(a_w) + (W+1)'(b_w);
    assign sub_s = (W+1)'(a_w) - (W+1)'(b_w);
    assign inc_s = (W+1)'(a_w) + (W+1)'(1);
    assign dec_s = (W+1)'(a_w) - (W+1)'(1);
    assign ma_next = a_w[W-1] ? W'(-a_w) : W'(a_w);
    assign mb_next = b_w[W-1] ? W'(-b_w) : W'(b_w);

    always_comb
    begin
        wide_s = XW'(add_s);
        unique case (op_w)
            OP_SUB:     wide_s = XW'(sub_s);
            OP_INC:     wide_s = XW'(inc_s);
            OP_DEC:     wide_s = XW'(dec_s);
            OP_INT2FIX: wide_s = XW'(a_w) <<< F;
            default:    wide_s = XW'(add_s);
        endcase
        clamped = clamp(wide_s);

        ctl_next       = '0;
        ctl_next.op    = op_w;
        ctl_next.neg   = a_w[W-1] ^ b_w[W-1];
        res_v          = '0;
        unique case (op_w)
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_INT2FIX:
            begin
                res_v        = clamped[W-1:0];
                ctl_next.ovf = clamped[W];
            end
            OP_DIV:
            begin
                if (b_w == '0)
                begin
                    ctl_next.dbz = 1'b1;
                    res_v = a_w[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                end
            end
            OP_GT:      ctl_next.cmp = a_w > b_w;
            OP_LT:      ctl_next.cmp = a_w < b_w;
            OP_GE:      ctl_next.cmp = a_w >= b_w;
            OP_LE:      ctl_next.cmp = a_w <= b_w;
            OP_EQ:      ctl_next.cmp = a_w == b_w;
            OP_NE:      ctl_next.cmp = a_w != b_w;
            OP_MIN:     res_v = (b_w < a_w) ? b_w : a_w;
            OP_MAX:     res_v = (b_w > a_w) ? b_w : a_w;
            OP_FIX2INT: res_v = a_w >>> F;
            default:    res_v = '0;
        endcase
        ctl_next.value = DATA_W'(res_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg <= ctl_next;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            ctl2_reg <= ctl1_reg;
            prod_reg <= ma_reg * mb_reg;
            num_reg  <= {ma_reg, {F{1'b0}}};
            den_reg  <= mb_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_ctl   = ctl2_reg;
    assign out_prod  = prod_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

endmodule

`default_nettype wire

// ----- hdl/fpa_div_step.sv -----
`default_nettype none

module fpa_div_step #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire fpa_pkg::fpa_ctl_t                  in_ctl,
    input  wire logic [2*WORD_BITS-1:0]             in_prod,
    input  wire logic [WORD_BITS+FRAC_BITS-1:0]     in_num,
    input  wire logic [WORD_BITS-1:0]               in_den,
    input  wire logic [WORD_BITS-1:0]               in_rem,
    input  wire logic [WORD_BITS+FRAC_BITS-1:0]     in_quo,
    output logic                                    out_valid,
    output fpa_pkg::fpa_ctl_t                       out_ctl,
    output logic [2*WORD_BITS-1:0]                  out_prod,
    output logic [WORD_BITS+FRAC_BITS-1:0]          out_num,
    output logic [WORD_BITS-1:0]                    out_den,
    output logic [WORD_BITS-1:0]                    out_rem,
    output logic [WORD_BITS+FRAC_BITS-1:0]          out_quo
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NW = WORD_BITS + FRAC_BITS;

    logic [W:0]    trial;
    logic          fits;
    logic [W:0]    diff;

    logic          valid_reg;
    fpa_ctl_t      ctl_reg;
    logic [2*W-1:0] prod_reg;
    logic [NW-1:0] num_reg;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  rem_reg;
    logic [NW-1:0] quo_reg;

    assign trial = {in_rem, in_num[NW-1]};
    assign fits  = trial >= {1'b0, in_den};
    assign diff  = trial - {1'b0, in_den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg  <= in_ctl;
            prod_reg <= in_prod;
            num_reg  <= {in_num[NW-2:0], 1'b0};
            den_reg  <= in_den;
            rem_reg  <= fits ? diff[W-1:0] : trial[W-1:0];
            quo_reg  <= {in_quo[NW-2:0], fits};
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_prod  = prod_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

`default_nettype wire

// ----- hdl/fpa_back.sv -----
`default_nettype none

module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire fpa_pkg::fpa_ctl_t                  in_ctl,
    input  wire logic [2*WORD_BITS-1:0]             in_prod,
    input  wire logic [WORD_BITS-1:0]               in_den,
    input  wire logic [WORD_BITS-1:0]               in_rem,
    input  wire logic [WORD_BITS+FRAC_BITS-1:0]     in_quo,
    output logic                                    out_valid,
    output logic [fpa_pkg::DATA_W-1:0]              out_value,
    output logic                                    out_cmp,
    output logic                                    out_ovf,
    output logic                                    out_dbz
);
    import fpa_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NW  = W + F;
    localparam int PW  = 2 * W + 1;
    localparam int MLW = PW - F;
    localparam int DLW = NW + 1;
    localparam int MW  = (MLW > DLW) ? MLW : DLW;
    localparam logic [PW-1:0] HALF    = PW'(1) << (F - 1);
    localparam logic [MW-1:0] LIM_POS = (MW'(1) << (W - 1)) - MW'(1);
    localparam logic [MW-1:0] LIM_NEG = MW'(1) << (W - 1);

    logic [PW-1:0]       prod_rnd;
    logic                div_up;
    logic [DLW-1:0]      div_mag;
    logic [MW-1:0]       mag;
    logic [MW-1:0]       lim;
    logic signed [W-1:0] res_v;
    logic                res_ovf;
    logic                use_calc;
    logic [DATA_W-1:0]   value_next;
    logic                ovf_next;

    logic                valid_reg;
    logic [DATA_W-1:0]   value_reg;
    logic                cmp_reg;
    logic                ovf_reg;
    logic                dbz_reg;

    assign prod_rnd = PW'(in_prod) + HALF;
    assign div_up   = {in_rem, 1'b0} >= {1'b0, in_den};
    assign div_mag  = DLW'(in_quo) + DLW'(div_up);
    assign mag      = (in_ctl.op == OP_MUL) ? MW'(prod_rnd[PW-1:F]) : MW'(div_mag);
    assign lim      = in_ctl.neg ? LIM_NEG : LIM_POS;
    assign use_calc = (in_ctl.op == OP_MUL) || ((in_ctl.op == OP_DIV) && !in_ctl.dbz);

    always_comb
    begin
        if (mag > lim)
        begin
            res_ovf = 1'b1;
            res_v   = in_ctl.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            res_ovf = 1'b0;
            res_v   = in_ctl.neg ? -mag[W-1:0] : mag[W-1:0];
        end
        value_next = use_calc ? DATA_W'(res_v) : in_ctl.value;
        ovf_next   = use_calc ? res_ovf : in_ctl.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            cmp_reg   <= in_ctl.cmp;
            ovf_reg   <= ovf_next;
            dbz_reg   <= in_ctl.dbz;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_cmp   = cmp_reg;
    assign out_ovf   = ovf_reg;
    assign out_dbz   = dbz_reg;

endmodule

`default_nettype wire

// ----- hdl/fixed_point_alu.sv -----
// Signed fixed-point ALU on raw words with FRAC_BITS fraction bits.
// Input channel s_*: s_tuser carries the opcode, s_tdata carries a_raw in
// bits 31:0 and b_raw in bits 63:32. Output channel m_*: m_tdata carries
// value_raw, m_tuser carries compare_true, overflow and divide_by_zero.
// Each input word yields exactly one output word, in order.
// Throughput is one word per cycle while the receiver does not stall. The
// restoring divider resolves one quotient bit per pipeline stage.
// Reset empties every stage; no output word is valid after reset.
// When the receiver stalls, the whole pipeline holds and one more input
// word is taken into a skid register before s_tready falls.
`default_nettype none

module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [2*fpa_pkg::DATA_W-1:0]     s_tdata,  // a_raw, b_raw
    input  wire logic [fpa_pkg::OP_W-1:0]         s_tuser,  // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [fpa_pkg::DATA_W-1:0]            m_tdata,  // value_raw
    output logic [2:0]                            m_tuser   // compare_true, overflow, divide_by_zero
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NW = WORD_BITS + FRAC_BITS;

    logic                   en;
    logic                   skid_valid_reg;
    logic [2*DATA_W-1:0]    skid_data_reg;
    logic [OP_W-1:0]        skid_op_reg;
    logic                   f_valid;
    logic [2*DATA_W-1:0]    f_data;
    logic [OP_W-1:0]        f_op;

    logic                   v_pipe    [0:NW];
    fpa_ctl_t               ctl_pipe  [0:NW];
    logic [2*W-1:0]         prod_pipe [0:NW];
    logic [NW-1:0]          num_pipe  [0:NW];
    logic [W-1:0]           den_pipe  [0:NW];
    logic [W-1:0]           rem_pipe  [0:NW];
    logic [NW-1:0]          quo_pipe  [0:NW];

    logic                   out_cmp;
    logic                   out_ovf;
    logic                   out_dbz;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign f_valid  = skid_valid_reg || s_tvalid;
    assign f_data   = skid_valid_reg ? skid_data_reg : s_tdata;
    assign f_op     = skid_valid_reg ? skid_op_reg : s_tuser;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && s_tvalid && s_tready)
        begin
            skid_data_reg <= s_tdata;
            skid_op_reg   <= s_tuser;
        end
    end

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_op     (f_op),
        .in_a      (f_data[DATA_W-1:0]),
        .in_b      (f_data[2*DATA_W-1:DATA_W]),
        .out_valid (v_pipe[0]),
        .out_ctl   (ctl_pipe[0]),
        .out_prod  (prod_pipe[0]),
        .out_num   (num_pipe[0]),
        .out_den   (den_pipe[0])
    );

    assign rem_pipe[0] = '0;
    assign quo_pipe[0] = '0;

    for (genvar i = 0; i < NW; i++)
    begin : g_div
        fpa_div_step #(
            .FRAC_BITS (FRAC_BITS),
            .WORD_BITS (WORD_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_pipe[i]),
            .in_ctl    (ctl_pipe[i]),
            .in_prod   (prod_pipe[i]),
            .in_num    (num_pipe[i]),
            .in_den    (den_pipe[i]),
            .in_rem    (rem_pipe[i]),
            .in_quo    (quo_pipe[i]),
            .out_valid (v_pipe[i+1]),
            .out_ctl   (ctl_pipe[i+1]),
            .out_prod  (prod_pipe[i+1]),
            .out_num   (num_pipe[i+1]),
            .out_den   (den_pipe[i+1]),
            .out_rem   (rem_pipe[i+1]),
            .out_quo   (quo_pipe[i+1])
        );
    end

    fpa_back #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_pipe[NW]),
        .in_ctl    (ctl_pipe[NW]),
        .in_prod   (prod_pipe[NW]),
        .in_den    (den_pipe[NW]),
        .in_rem    (rem_pipe[NW]),
        .in_quo    (quo_pipe[NW]),
        .out_valid (m_tvalid),
        .out_value (m_tdata),
        .out_cmp   (out_cmp),
        .out_ovf   (out_ovf),
        .out_dbz   (out_dbz)
    );

    assign m_tuser = {out_dbz, out_ovf, out_cmp};

endmodule

`default_nettype wire

// ----- hdl/fpa_checker.sv -----
`default_nettype none

`include "fixed_point_alu_assert.svh"

module fpa_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [2:0]  m_tuser
);

    `FPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Output word changed while stalled.")
    `FPA_ASSERT_SAME(a_cmp_clean, m_tvalid && m_tuser[0], (m_tdata == 32'd0) && !m_tuser[1] && !m_tuser[2], "Comparison word carries a value or a flag.")
    `FPA_ASSERT_SAME(a_dbz_only, m_tvalid && m_tuser[2], !m_tuser[1] && !m_tuser[0], "Divide by zero raised together with another flag.")

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- verif/fixed_point_alu_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none

module fixed_point_alu_checker
    import fpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [2*DATA_W-1:0]   s_tdata,
    input  wire logic [OP_W-1:0]       s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [DATA_W-1:0]     m_tdata,
    input  wire logic [2:0]            m_tuser,
    output int                         fail_count,
    output int                         pending_count,
    output int                         result_count
);

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        ovf;
        logic        dbz;
    } alu_result_t;

    alu_result_t expected_results[$];

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    function automatic longint saturate(input longint v, inout logic ovf);
        if (v > WMAX)
        begin
            ovf = 1'b1;
            return WMAX;
        end
        if (v < WMIN)
        begin
            ovf = 1'b1;
            return WMIN;
        end
        return v;
    endfunction

    function automatic alu_result_t compute_alu(input fpa_op_t op, input logic [31:0] ar,
                                                input logic [31:0] br);
        longint a;
        longint b;
        longint v;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mag;
        logic [63:0] num;
        logic neg;
        alu_result_t r;
        a = longint'($signed(ar));
        b = longint'($signed(br));
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        r = '0;
        v = 0;
        case (op)
            OP_ADD: v = saturate(a + b, r.ovf);
            OP_SUB: v = saturate(a - b, r.ovf);
            OP_MUL, OP_DIV:
            begin
                if (op == OP_DIV && b == 0)
                begin
                    r.dbz = 1'b1;
                    v = (a < 0) ? WMIN : WMAX;
                end
                else
                begin
                    if (op == OP_MUL)
                        mag = (ma * mb + 64'd128) >> 8;
                    else
                    begin
                        num = ma << 8;
                        mag = (2 * num + mb) / (2 * mb);
                    end
                    v = saturate(neg ? -longint'(mag) : longint'(mag), r.ovf);
                end
            end
            OP_GT: r.cmp = a > b;
            OP_LT: r.cmp = a < b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: v = (b < a) ? b : a;
            OP_MAX: v = (b > a) ? b : a;
            OP_INC: v = saturate(a + 1, r.ovf);
            OP_DEC: v = saturate(a - 1, r.ovf);
            OP_INT2FIX: v = saturate(a * 256, r.ovf);
            default: v = a >>> 8;
        endcase
        r.value = v[31:0];
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        result_count = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        alu_result_t want;
        alu_result_t got;
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(compute_alu(fpa_op_t'(s_tuser), s_tdata[31:0],
                                                   s_tdata[63:32]));
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata, m_tuser[0], m_tuser[1], m_tuser[2]};
            result_count <= result_count + 1;
            if (expected_results.size() == 0)
            begin
                $error("Output word with no word expected: %h", m_tdata);
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.value !== want.value)
                    $error("value_raw: expected %h, actual %h", want.value, got.value);
                if (got.cmp !== want.cmp)
                    $error("compare_true: expected %b, actual %b", want.cmp, got.cmp);
                if (got.ovf !== want.ovf)
                    $error("overflow: expected %b, actual %b", want.ovf, got.ovf);
                if (got.dbz !== want.dbz)
                    $error("divide_by_zero: expected %b, actual %b", want.dbz, got.dbz);
                if (got !== want)
                    fail_count <= fail_count + 1;
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

`default_nettype wire

// ----- verif/fixed_point_alu_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module fixed_point_alu_tb;
    import fpa_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*DATA_W-1:0] s_tdata = '0;  // a_raw, b_raw
    logic [OP_W-1:0]     s_tuser = '0;  // op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;       // value_raw
    logic [2:0]          m_tuser;       // compare_true, overflow, divide_by_zero
    int                  fail_count;
    int                  pending_count;
    int                  result_count;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  words_sent = 0;

    always #5 clk = ~clk;

    fixed_point_alu uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    fixed_point_alu_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return $urandom_range(3) - 1;
            3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            4: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
            5: return 32'($urandom_range(255)) << 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input fpa_op_t op, input logic [31:0] a, input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] edges [6];
        int waited;
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'h80};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int op = 0; op < 16; op++)
            send_word(fpa_op_t'(op), edges[op % 6], edges[(op + 2) % 6]);
        send_word(OP_DIV, 32'h0, 32'h0);
        send_word(OP_DIV, 32'hFFFF_FF00, 32'h0);
        send_word(OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
        send_word(OP_MUL, 32'h8000_0000, 32'hFFFF_FF00);
        send_word(OP_MUL, 32'h0000_0001, 32'h0000_0080);
        send_word(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
        send_word(OP_DIV, 32'h0000_0001, 32'h0000_0200);
        send_word(OP_MIN, 32'h5, 32'h5);
        send_word(OP_FIX2INT, 32'hFFFF_FFFF, 32'h0);
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 16 : 67) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 16 : 67) : 0;
            for (int i = 0; i < 300; i++)
                send_word(fpa_op_t'($urandom_range(15)), pick_operand(), pick_operand());
        end
        s_tvalid <= 1'b0;
        stall_pct = 0;
        waited = 0;
        while (pending_count != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        $display("Sent %0d words over all 16 opcodes, operand extremes and four idle patterns.",
                 words_sent);
        $display("Checked %0d output words.", result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/fpa_pkg.sv
hdl/fpa_front.sv
hdl/fpa_div_step.sv
hdl/fpa_back.sv
hdl/fixed_point_alu.sv
hdl/fpa_checker.sv
verif/fixed_point_alu_checker.sv
verif/fixed_point_alu_tb.sv
